[rtl/fgs_pkg.sv]
// Shared types, constants and table functions for the Fourier-space Gaussian smoothing block.
`timescale 1ns / 1ps

package fgs_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GRID_SIZE   = 2'd0;
    localparam logic [1:0] CFG_WAVE_STEP   = 2'd1;
    localparam logic [1:0] CFG_WAVE_MAX    = 2'd2;
    localparam logic [1:0] CFG_SMOOTH_LEN  = 2'd3;

    // Field widths fixed by the interface.
    localparam int IDX_W    = 10;
    localparam int GRID_W   = 11;
    localparam int SAMPLE_W = 32;

    // 0.5*log2(e) in Q0.32 and (2*pi)^-1.5 in Q2.30.
    localparam logic [31:0] LOG2E_HALF = 32'd3098164009;
    localparam logic [26:0] INV_2PI_15 = 27'd68175773;

    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;

    // Largest supported table address width.
    localparam int TAB_BITS_MAX = 12;

    // Per-item data that travels beside the arithmetic through the pipeline.
    typedef struct packed {
        logic                err;
        logic                kill;
        logic                neg_re;
        logic                neg_im;
        logic [SAMPLE_W-1:0] mag_re;
        logic [SAMPLE_W-1:0] mag_im;
    } side_t;

    // Floor square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] probe;
        rem   = val;
        res   = '0;
        probe = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (probe > rem) begin
                probe = probe >> 2;
            end
        end
        for (int s = 0; s < 32; s++) begin
            if (probe != '0) begin
                if (rem >= res + probe) begin
                    rem = rem - (res + probe);
                    res = (res >> 1) + probe;
                end else begin
                    res = res >> 1;
                end
                probe = probe >> 2;
            end
        end
        return res;
    endfunction

    // Table entry 2^-(idx / 2^bits) in Q1.30, built from repeated square roots of one half.
    function automatic logic [30:0] exp_entry(input int idx, input int bits);
        logic [63:0] roots [0:TAB_BITS_MAX];
        logic [63:0] acc;
        for (int j = 0; j <= TAB_BITS_MAX; j++) begin
            roots[j] = '0;
        end
        acc = Q30_ONE;
        if (idx >= (1 << bits)) begin
            acc = Q30_HALF;
        end else begin
            roots[0] = Q30_HALF;
            for (int j = 1; j <= TAB_BITS_MAX; j++) begin
                if (j <= bits) begin
                    roots[j] = isqrt64(roots[j-1] << 30);
                end
            end
            for (int p = 0; p < TAB_BITS_MAX; p++) begin
                if (p < bits && ((idx >> p) & 1) == 1) begin
                    acc = (acc * roots[bits-p] + Q30_HALF) >> 30;
                end
            end
        end
        return acc[30:0];
    endfunction

endpackage

[rtl/fourier_gaussian_smoothing.sv]
// Top level of the Fourier-space Gaussian smoothing pipeline.
`timescale 1ns / 1ps

// Gaussian smoothing of Fourier coefficients of a half-complex 3D grid. Each request on the
// slave stream carries three grid indices and one complex coefficient; the block turns the
// indices into signed wave numbers, forms x = s^2 * |k|^2, evaluates exp(-x/2)*(2*pi)^-1.5
// as a power of two from an interpolated table, and scales both parts of the coefficient.
// Exactly one result leaves the master stream per request, in order. The datapath is a
// thirteen-stage pipeline that takes one request per clock cycle while the master side is
// not stalled; the rate is set by the single pass through the stages, and no
// path through a stage holds more than one multiplication. Every stage has its own valid
// bit and moves whenever the stage after it is empty or moving, so bubbles close up while
// the master side stalls and the slave side keeps taking requests until the pipeline is
// full. Indices outside the configured grid give a zero result with the error flag in
// m_tuser set. Configuration registers may only be written while no request is in flight.
module fourier_gaussian_smoothing
    import fgs_pkg::*;
#(
    parameter int MAX_GRID       = 1024,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_index,
    input  logic [31:0]  cfg_wr_data,

    input  logic         s_tvalid,
    output logic         s_tready,
    // index_a [9:0], index_b [19:10], index_c [29:20], sample_re [61:30],
    // sample_im [93:62], zero padding [95:94]
    input  logic [95:0]  s_tdata,

    output logic         m_tvalid,
    input  logic         m_tready,
    // filtered_re [31:0], filtered_im [63:32]
    output logic [63:0]  m_tdata,
    // index_error [0]
    output logic [0:0]   m_tuser
);

    localparam int NST      = 13;
    localparam int SIDE_N   = NST - 1;
    localparam int TAB_N    = 1 << EXP_TABLE_BITS;
    localparam int SH       = 24 - EXP_TABLE_BITS;
    localparam int DR_W     = 31 + SH;
    localparam logic [GRID_W-1:0] GRID_CAP =
        GRID_W'((MAX_GRID > 2047) ? 2047 : MAX_GRID);
    localparam logic [DR_W-1:0] DR_RND = DR_W'(1) << (SH - 1);

    // Configuration registers.
    logic [GRID_W-1:0] grid_size_reg;
    logic [23:0]       wave_step_reg;
    logic [31:0]       wave_max_reg;
    logic [23:0]       smooth_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg  <= GRID_W'(256);
            wave_step_reg  <= 24'd65536;
            wave_max_reg   <= 32'd16777216;
            smooth_len_reg <= 24'd65536;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_GRID_SIZE:  grid_size_reg  <= cfg_wr_data[GRID_W-1:0];
                CFG_WAVE_STEP:  wave_step_reg  <= cfg_wr_data[23:0];
                CFG_WAVE_MAX:   wave_max_reg   <= cfg_wr_data;
                CFG_SMOOTH_LEN: smooth_len_reg <= cfg_wr_data[23:0];
                default: ;
            endcase
        end
    end

    // Exponential table: 2^-(i/TAB_N) in Q1.30, fixed at elaboration.
    logic [30:0] exp_rom [0:TAB_N-1];

    for (genvar gi = 0; gi < TAB_N; gi++) begin : g_rom
        localparam logic [30:0] ENT = exp_entry(gi, EXP_TABLE_BITS);
        assign exp_rom[gi] = ENT;
    end

    // Pipeline flow control: a stage loads when it is empty or its successor loads.
    logic [NST:1] vld_reg;
    logic [NST:1] vld_in;
    logic [NST:1] vld_next;
    logic [NST:1] stage_en;

    always_comb begin
        stage_en[NST] = ~vld_reg[NST] | m_tready;
        for (int k = NST - 1; k >= 1; k--) begin
            stage_en[k] = ~vld_reg[k] | stage_en[k+1];
        end
    end

    assign vld_in   = {vld_reg[NST-1:1], s_tvalid};
    assign vld_next = (stage_en & vld_in) | (~stage_en & vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = stage_en[1];
    assign m_tvalid = vld_reg[NST];

    // Sideband carried along the stages.
    side_t side_reg  [1:SIDE_N];
    side_t side_next [1:SIDE_N];

    // Stage 1: grid check, wrap decision and index times dk.
    logic [GRID_W-1:0] grid_n;
    logic [GRID_W-1:0] grid_half;
    logic [IDX_W-1:0]  idx_in [3];
    logic [33:0]       s1_base_next [3];
    logic [2:0]        s1_wrap_next;
    logic              s1_err;
    logic [SAMPLE_W-1:0] in_re;
    logic [SAMPLE_W-1:0] in_im;
    logic [33:0]       s1_base_reg [3];
    logic [2:0]        s1_wrap_reg;

    assign grid_n    = (grid_size_reg > GRID_CAP) ? GRID_CAP : grid_size_reg;
    assign grid_half = grid_n >> 1;
    assign idx_in[0] = s_tdata[9:0];
    assign idx_in[1] = s_tdata[19:10];
    assign idx_in[2] = s_tdata[29:20];
    assign in_re     = s_tdata[61:30];
    assign in_im     = s_tdata[93:62];
    assign s1_err    = ({1'b0, idx_in[0]} >= grid_n) || ({1'b0, idx_in[1]} >= grid_n) ||
                       ({1'b0, idx_in[2]} > grid_half);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s1_base_next[a] = 34'(idx_in[a]) * 34'(wave_step_reg);
            s1_wrap_next[a] = {1'b0, idx_in[a]} >= grid_half;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s1_base_reg <= s1_base_next;
            s1_wrap_reg <= s1_wrap_next;
        end
    end

    // Stage 2: magnitude of the wrapped wave number.
    logic [33:0] s2_mag_next [3];
    logic [33:0] s2_mag_reg  [3];
    logic [33:0] wmax_ext;

    assign wmax_ext = 34'(wave_max_reg);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (!s1_wrap_reg[a]) begin
                s2_mag_next[a] = s1_base_reg[a];
            end else if (s1_base_reg[a] >= wmax_ext) begin
                s2_mag_next[a] = s1_base_reg[a] - wmax_ext;
            end else begin
                s2_mag_next[a] = wmax_ext - s1_base_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s2_mag_reg <= s2_mag_next;
        end
    end

    // Stage 3: u = |k| * s in Q.16; anything at or above 8.0 forces a zero factor.
    logic [57:0] s3_prod [3];
    logic [18:0] s3_u_next [3];
    logic [18:0] s3_u_reg  [3];
    logic        s3_big;

    always_comb begin
        s3_big = 1'b0;
        for (int a = 0; a < 3; a++) begin
            s3_prod[a]   = 58'(s2_mag_reg[a]) * 58'(smooth_len_reg);
            s3_u_next[a] = s3_prod[a][34:16];
            s3_big       = s3_big | (|s3_prod[a][57:35]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s3_u_reg <= s3_u_next;
        end
    end

    // Stage 4: squares per axis.
    logic [37:0] s4_sq_reg [3];

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            for (int a = 0; a < 3; a++) begin
                s4_sq_reg[a] <= 38'(s3_u_reg[a]) * 38'(s3_u_reg[a]);
            end
        end
    end

    // Stage 5: x in Q.32; 64.0 or more forces a zero factor.
    logic [39:0] s5_sum;
    logic        s5_big;
    logic [37:0] s5_x_reg;

    assign s5_sum = 40'(s4_sq_reg[0]) + 40'(s4_sq_reg[1]) + 40'(s4_sq_reg[2]);
    assign s5_big = |s5_sum[39:38];

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            s5_x_reg <= s5_sum[37:0];
        end
    end

    // Stage 6: y = x * log2(e) / 2 in Q.24.
    logic [61:0] s6_prod;
    logic [29:0] s6_y_reg;

    assign s6_prod = 62'(s5_x_reg[37:8]) * 62'(LOG2E_HALF);

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            s6_y_reg <= s6_prod[61:32];
        end
    end

    // Stage 7: table reads around the fraction; the entry past the end is one half.
    logic [EXP_TABLE_BITS-1:0] s7_addr;
    logic [EXP_TABLE_BITS-1:0] s7_addr_nx;
    logic [30:0]               s7_e1_next;
    logic [30:0]               s7_e0_reg;
    logic [30:0]               s7_e1_reg;
    logic [SH-1:0]             s7_r_reg;
    logic [5:0]                s7_ip_reg;

    assign s7_addr    = s6_y_reg[23:SH];
    assign s7_addr_nx = s7_addr + EXP_TABLE_BITS'(1);
    assign s7_e1_next = (&s7_addr) ? Q30_HALF[30:0] : exp_rom[s7_addr_nx];

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            s7_e0_reg <= exp_rom[s7_addr];
            s7_e1_reg <= s7_e1_next;
            s7_r_reg  <= s6_y_reg[SH-1:0];
            s7_ip_reg <= s6_y_reg[29:24];
        end
    end

    // Stage 8: slope times remainder.
    logic [DR_W-1:0] s8_dr_reg;
    logic [30:0]     s8_e0_reg;
    logic [5:0]      s8_ip_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            s8_dr_reg <= DR_W'(s7_e0_reg - s7_e1_reg) * DR_W'(s7_r_reg);
            s8_e0_reg <= s7_e0_reg;
            s8_ip_reg <= s7_ip_reg;
        end
    end

    // Stage 9: interpolated fraction value.
    logic [DR_W-1:0] s9_dr_rnd;
    logic [30:0]     s9_v_reg;
    logic [5:0]      s9_ip_reg;

    assign s9_dr_rnd = s8_dr_reg + DR_RND;

    always_ff @(posedge aclk) begin
        if (stage_en[9]) begin
            s9_v_reg  <= s8_e0_reg - 31'(s9_dr_rnd >> SH);
            s9_ip_reg <= s8_ip_reg;
        end
    end

    // Stage 10: integer part of the exponent as a right shift.
    logic [30:0] s10_g_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[10]) begin
            s10_g_reg <= s9_v_reg >> s9_ip_reg;
        end
    end

    // Stage 11: apply the normalization constant; killed items get a zero factor.
    logic [57:0] s11_prod;
    logic [26:0] s11_h_reg;

    assign s11_prod = 58'(s10_g_reg) * 58'(INV_2PI_15) + 58'(Q30_HALF);

    always_ff @(posedge aclk) begin
        if (stage_en[11]) begin
            s11_h_reg <= side_reg[10].kill ? '0 : s11_prod[56:30];
        end
    end

    // Stage 12: scale both magnitudes with rounding half up.
    logic [58:0] s12_prod_re;
    logic [58:0] s12_prod_im;
    logic [28:0] s12_mag_re_reg;
    logic [28:0] s12_mag_im_reg;

    assign s12_prod_re = 59'(side_reg[11].mag_re) * 59'(s11_h_reg) + 59'(Q30_HALF);
    assign s12_prod_im = 59'(side_reg[11].mag_im) * 59'(s11_h_reg) + 59'(Q30_HALF);

    always_ff @(posedge aclk) begin
        if (stage_en[12]) begin
            s12_mag_re_reg <= s12_prod_re[58:30];
            s12_mag_im_reg <= s12_prod_im[58:30];
        end
    end

    // Stage 13: restore signs into the output register; error items leave as zero.
    logic [SAMPLE_W-1:0] out_re_reg;
    logic [SAMPLE_W-1:0] out_im_reg;
    logic                out_err_reg;
    logic [SAMPLE_W-1:0] out_re_next;
    logic [SAMPLE_W-1:0] out_im_next;

    assign out_re_next = side_reg[12].neg_re ? -SAMPLE_W'(s12_mag_re_reg)
                                             : SAMPLE_W'(s12_mag_re_reg);
    assign out_im_next = side_reg[12].neg_im ? -SAMPLE_W'(s12_mag_im_reg)
                                             : SAMPLE_W'(s12_mag_im_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[13]) begin
            out_re_reg  <= side_reg[12].err ? '0 : out_re_next;
            out_im_reg  <= side_reg[12].err ? '0 : out_im_next;
            out_err_reg <= side_reg[12].err;
        end
    end

    assign m_tdata = {out_im_reg, out_re_reg};
    assign m_tuser = out_err_reg;

    // Sideband: sign and magnitude of the coefficient, error and zero-factor flags.
    always_comb begin
        side_next[1].err    = s1_err;
        side_next[1].kill   = s1_err;
        side_next[1].neg_re = in_re[SAMPLE_W-1];
        side_next[1].neg_im = in_im[SAMPLE_W-1];
        side_next[1].mag_re = in_re[SAMPLE_W-1] ? -in_re : in_re;
        side_next[1].mag_im = in_im[SAMPLE_W-1] ? -in_im : in_im;
        for (int k = 2; k <= SIDE_N; k++) begin
            side_next[k] = side_reg[k-1];
        end
        side_next[3].kill = side_reg[2].kill | s3_big;
        side_next[5].kill = side_reg[4].kill | s5_big;
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= SIDE_N; k++) begin
            if (stage_en[k]) begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // Checks on the datapath.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("error result carries nonzero data");

    a_h_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[11] |-> s11_h_reg <= INV_2PI_15)
        else $error("scale factor above its maximum");

    a_kill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[11] && side_reg[11].kill |-> s11_h_reg == '0)
        else $error("saturated item has nonzero factor");

    a_tab_order: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[7] |-> s7_e0_reg >= s7_e1_reg)
        else $error("table entries out of order");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[1])
        else $error("accepted request did not enter the pipeline");

endmodule
